// ===== rtl/scaled_tiled_texture_blitter_core_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef SCALED_TILED_TEXTURE_BLITTER_CORE_MACROS_SVH
`define SCALED_TILED_TEXTURE_BLITTER_CORE_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stb_pkg.sv =====
`default_nettype none

package stb_pkg;

  localparam int MAGNIFY     = 5;
  localparam int REP_W       = $clog2(MAGNIFY + 1);
  localparam int TEXEL_COUNT = 4096;
  localparam int TEX_AW      = $clog2(TEXEL_COUNT);
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int WRAP_STEPS  = 16;
  localparam int WRAP_CW     = $clog2(WRAP_STEPS);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DW      = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_WIDTH     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_HEIGHT    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 4'd7;

  localparam logic [11:0] SCREEN_MAX   = 12'd2048;
  localparam logic [6:0]  TEX_DIM_MAX  = 7'd64;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_STEP
  } cmd_kind_t;

  typedef enum logic {
    BK_RUN,
    BK_WRAP
  } back_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] texel_index;
    logic [23:0] texel_rgb;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [23:0] pixel_rgb;
    logic        last_pixel;
  } pixel_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] index;
    logic [23:0] rgb;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [13:0]        rect_width;
    logic [13:0]        rect_height;
    logic [11:0]        surf_width;
    logic [11:0]        surf_height;
    logic [6:0]         texture_width;
    logic [6:0]         texture_height;
  } cfg_t;

  function automatic logic [6:0] clamp_tex(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > TEX_DIM_MAX) begin
      r = TEX_DIM_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scaled_tiled_texture_blitter_core.sv =====
// Tiled, magnified texture rectangle fill.
// Input: an item transfers when start is high and busy is low. op selects
// load texel (texel_index, texel_rgb), start draw, or step one pixel;
// op 3 is taken and dropped.
// Config: cfg_valid/cfg_ready write cfg_wdata to register cfg_index
// (origin, rect size, screen size, texture size); cfg_ready is always high.
// Values are latched by a start and used until the next start.
// Output: each pixel is on out_pixel for one cycle with out_valid high.
// The receiver cannot stall; there is no backpressure on the output.
// Path: a step passes the command queue, then the pixel register and texture read.
// Throughput: loads and steps run at one per cycle through a four-entry
// command queue while no start is in process. A start holds the draw engine
// for issue, the 16-step bit-serial origin modulo and a final state to latch
// the clipped bounds; busy rises once the queue fills behind it.
// Reset (synchronous, rst_n low): queue and draw state cleared, registers to
// their defaults; texture store contents are not cleared.
`default_nettype none

module scaled_tiled_texture_blitter_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire stb_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  output stb_pkg::pixel_t                       out_pixel,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [stb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stb_pkg::CFG_DW-1:0]       cfg_wdata
);

  stb_pkg::cfg_t        cfg_r, cfg_nxt;
  stb_pkg::queue_head_t head;
  logic                 pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stb_pkg::REG_ORIGIN_X:       cfg_nxt.origin_x       = cfg_wdata;
        stb_pkg::REG_ORIGIN_Y:       cfg_nxt.origin_y       = cfg_wdata;
        stb_pkg::REG_RECT_WIDTH:     cfg_nxt.rect_width     = cfg_wdata[13:0];
        stb_pkg::REG_RECT_HEIGHT:    cfg_nxt.rect_height    = cfg_wdata[13:0];
        stb_pkg::REG_SURF_WIDTH:     cfg_nxt.surf_width     = cfg_wdata[11:0];
        stb_pkg::REG_SURF_HEIGHT:    cfg_nxt.surf_height    = cfg_wdata[11:0];
        stb_pkg::REG_TEXTURE_WIDTH:  cfg_nxt.texture_width  = cfg_wdata[6:0];
        stb_pkg::REG_TEXTURE_HEIGHT: cfg_nxt.texture_height = cfg_wdata[6:0];
        default:                     cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x       <= '0;
      cfg_r.origin_y       <= '0;
      cfg_r.rect_width     <= '0;
      cfg_r.rect_height    <= '0;
      cfg_r.surf_width     <= 12'd640;
      cfg_r.surf_height    <= 12'd480;
      cfg_r.texture_width  <= 7'd64;
      cfg_r.texture_height <= 7'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .head    (head)
  );

  stb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

endmodule

`default_nettype wire

// ===== rtl/stb_ram.sv =====
`default_nettype none

module stb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stb_front.sv =====
`default_nettype none

module stb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire stb_pkg::in_item_t  in_item,
  input  wire logic               pop,
  output stb_pkg::queue_head_t    head
);

  stb_pkg::cmd_t                fifo_r [stb_pkg::QUEUE_DEPTH];
  logic [stb_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [stb_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [stb_pkg::Q_AW:0]       count_r, count_nxt;
  logic                         accept;
  logic                         push;
  stb_pkg::cmd_t                push_cmd;

  assign busy   = (count_r == (stb_pkg::Q_AW + 1)'(stb_pkg::QUEUE_DEPTH));
  assign accept = start && !busy;

  // classify; unused op codes are taken and dropped
  always_comb begin
    push_cmd.kind  = stb_pkg::CMD_LOAD;
    push_cmd.index = in_item.texel_index;
    push_cmd.rgb   = in_item.texel_rgb;
    push           = 1'b0;
    unique case (in_item.op)
      stb_pkg::OP_LOAD: begin
        push_cmd.kind = stb_pkg::CMD_LOAD;
        push          = accept;
      end
      stb_pkg::OP_START: begin
        push_cmd.kind = stb_pkg::CMD_START;
        push          = accept;
      end
      stb_pkg::OP_STEP: begin
        push_cmd.kind = stb_pkg::CMD_STEP;
        push          = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (stb_pkg::Q_AW)'(push);
    rd_ptr_nxt = rd_ptr_r + (stb_pkg::Q_AW)'(pop);
    count_nxt  = count_r + (stb_pkg::Q_AW + 1)'(push) - (stb_pkg::Q_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = fifo_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/stb_wrap.sv =====
`default_nettype none

module stb_wrap (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic signed [15:0] value,
  input  wire logic [6:0]         modulus,
  output logic                    done,
  output logic [5:0]              result
);

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [stb_pkg::WRAP_CW-1:0]   cnt_r, cnt_nxt;
  logic [15:0]                   mag_r, mag_nxt;
  logic [5:0]                    rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [6:0]                    mod_r, mod_nxt;
  logic [6:0]                    shifted;
  logic [6:0]                    diff;

  // restoring remainder on the magnitude, one bit per cycle
  assign shifted = {rem_r, mag_r[15]};
  assign diff    = shifted - mod_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    mod_nxt  = mod_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      mag_nxt = value[15] ? (~value + 16'd1) : value;
      rem_nxt = '0;
      neg_nxt = value[15];
      mod_nxt = modulus;
    end else if (run_r) begin
      mag_nxt = {mag_r[14:0], 1'b0};
      rem_nxt = (shifted >= mod_r) ? diff[5:0] : shifted[5:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == (stb_pkg::WRAP_CW)'(stb_pkg::WRAP_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    mod_r <= mod_nxt;
  end

  // non-negative result for a negative operand
  logic [6:0] flip;
  assign flip   = mod_r - {1'b0, rem_r};
  assign done   = done_r;
  assign result = (neg_r && rem_r != '0) ? flip[5:0] : rem_r;

endmodule

`default_nettype wire

// ===== rtl/stb_back.sv =====
`default_nettype none
`include "scaled_tiled_texture_blitter_core_macros.svh"

module stb_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire stb_pkg::cfg_t        cfg,
  input  wire stb_pkg::queue_head_t head,
  output logic                      pop,
  output logic                      out_valid,
  output stb_pkg::pixel_t           out_pixel
);

  stb_pkg::back_state_t        state_r, state_nxt;
  logic                        drawing_r, drawing_nxt;
  logic [10:0]                 cur_col_r, cur_col_nxt;
  logic [10:0]                 cur_row_r, cur_row_nxt;
  logic [5:0]                  tex_col_r, tex_col_nxt;
  logic [5:0]                  tex_row_r, tex_row_nxt;
  logic [5:0]                  tex_col_start_r, tex_col_start_nxt;
  logic [stb_pkg::REP_W-1:0]   col_rep_r, col_rep_nxt;
  logic [stb_pkg::REP_W-1:0]   row_rep_r, row_rep_nxt;
  logic [10:0]                 col_start_r, col_start_nxt;
  logic [11:0]                 col_end_r, col_end_nxt;
  logic [11:0]                 row_end_r, row_end_nxt;
  logic [6:0]                  lat_tw_r, lat_tw_nxt;
  logic [6:0]                  lat_th_r, lat_th_nxt;
  logic                        s1_vld_r, s1_vld_nxt;
  logic [10:0]                 s1_x_r, s1_x_nxt;
  logic [10:0]                 s1_y_r, s1_y_nxt;
  logic                        s1_last_r, s1_last_nxt;

  logic                        go;
  logic                        x_done, y_done;
  logic [5:0]                  x_res, y_res;
  logic [6:0]                  cfg_tw, cfg_th;
  logic                        ram_we, ram_re;
  logic [23:0]                 ram_rdata;
  logic [12:0]                 tex_prod;
  logic [13:0]                 tex_addr;
  logic                        step_fire;
  logic                        last;

  logic [stb_pkg::REP_W:0]     col_rep_inc, row_rep_inc;
  logic [6:0]                  tex_col_inc, tex_row_inc;
  logic [11:0]                 col_inc, row_inc, cur_col_ext;

  logic signed [16:0]          x0, y0, x1, y1, x1c, y1c, sw_s, sh_s;
  logic [11:0]                 sw_c, sh_c;
  logic                        empty;

  assign cfg_tw = stb_pkg::clamp_tex(cfg.texture_width);
  assign cfg_th = stb_pkg::clamp_tex(cfg.texture_height);

  stb_wrap u_wrap_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .value   (cfg.origin_x),
    .modulus (cfg_tw),
    .done    (x_done),
    .result  (x_res)
  );

  stb_wrap u_wrap_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .value   (cfg.origin_y),
    .modulus (cfg_th),
    .done    (y_done),
    .result  (y_res)
  );

  assign tex_prod = tex_row_r * lat_tw_r;
  assign tex_addr = {1'b0, tex_prod} + {8'd0, tex_col_r};

  stb_ram #(
    .WIDTH (24),
    .DEPTH (stb_pkg::TEXEL_COUNT)
  ) u_tex_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (head.cmd.index[stb_pkg::TEX_AW-1:0]),
    .wr_data (head.cmd.rgb),
    .rd_en   (ram_re),
    .rd_addr (tex_addr[stb_pkg::TEX_AW-1:0]),
    .rd_data (ram_rdata)
  );

  // clipping against screen, evaluated when the wrap units finish
  assign sw_c = (cfg.surf_width > stb_pkg::SCREEN_MAX) ? stb_pkg::SCREEN_MAX
                                                        : cfg.surf_width;
  assign sh_c = (cfg.surf_height > stb_pkg::SCREEN_MAX) ? stb_pkg::SCREEN_MAX
                                                         : cfg.surf_height;
  assign sw_s = $signed({5'd0, sw_c});
  assign sh_s = $signed({5'd0, sh_c});
  assign x0   = cfg.origin_x[15] ? 17'sd0 : $signed({1'b0, cfg.origin_x});
  assign y0   = cfg.origin_y[15] ? 17'sd0 : $signed({1'b0, cfg.origin_y});
  assign x1   = $signed({cfg.origin_x[15], cfg.origin_x}) + $signed({3'd0, cfg.rect_width});
  assign y1   = $signed({cfg.origin_y[15], cfg.origin_y}) + $signed({3'd0, cfg.rect_height});
  assign x1c  = (x1 > sw_s) ? sw_s : x1;
  assign y1c  = (y1 > sh_s) ? sh_s : y1;
  assign empty = (x0 >= x1c) || (y0 >= y1c);

  assign col_rep_inc = {1'b0, col_rep_r} + 1'b1;
  assign row_rep_inc = {1'b0, row_rep_r} + 1'b1;
  assign tex_col_inc = {1'b0, tex_col_r} + 7'd1;
  assign tex_row_inc = {1'b0, tex_row_r} + 7'd1;
  assign col_inc     = {1'b0, cur_col_r} + 12'd1;
  assign row_inc     = {1'b0, cur_row_r} + 12'd1;
  assign cur_col_ext = {1'b0, cur_col_r};
  assign last        = (col_inc == col_end_r) && (row_inc == row_end_r);

  assign pop       = (state_r == stb_pkg::BK_RUN) && head.valid;
  assign step_fire = pop && (head.cmd.kind == stb_pkg::CMD_STEP) && drawing_r;

  always_comb begin
    state_nxt         = state_r;
    drawing_nxt       = drawing_r;
    cur_col_nxt       = cur_col_r;
    cur_row_nxt       = cur_row_r;
    tex_col_nxt       = tex_col_r;
    tex_row_nxt       = tex_row_r;
    tex_col_start_nxt = tex_col_start_r;
    col_rep_nxt       = col_rep_r;
    row_rep_nxt       = row_rep_r;
    col_start_nxt     = col_start_r;
    col_end_nxt       = col_end_r;
    row_end_nxt       = row_end_r;
    lat_tw_nxt        = lat_tw_r;
    lat_th_nxt        = lat_th_r;
    s1_vld_nxt        = 1'b0;
    s1_x_nxt          = s1_x_r;
    s1_y_nxt          = s1_y_r;
    s1_last_nxt       = s1_last_r;
    go                = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    unique case (state_r)
      stb_pkg::BK_RUN: begin
        if (pop) begin
          unique case (head.cmd.kind)
            stb_pkg::CMD_LOAD: begin
              ram_we = (32'(head.cmd.index) < stb_pkg::TEXEL_COUNT);
            end
            stb_pkg::CMD_START: begin
              go         = 1'b1;
              lat_tw_nxt = cfg_tw;
              lat_th_nxt = cfg_th;
              state_nxt  = stb_pkg::BK_WRAP;
            end
            stb_pkg::CMD_STEP: begin
              if (drawing_r) begin
                ram_re      = 1'b1;
                s1_vld_nxt  = 1'b1;
                s1_x_nxt    = cur_col_r;
                s1_y_nxt    = cur_row_r;
                s1_last_nxt = last;
                if (col_rep_inc >= (stb_pkg::REP_W + 1)'(stb_pkg::MAGNIFY)) begin
                  col_rep_nxt = '0;
                  tex_col_nxt = (tex_col_inc >= lat_tw_r) ? 6'd0 : tex_col_inc[5:0];
                end else begin
                  col_rep_nxt = col_rep_inc[stb_pkg::REP_W-1:0];
                end
                if (col_inc >= col_end_r) begin
                  cur_col_nxt = col_start_r;
                  tex_col_nxt = tex_col_start_r;
                  col_rep_nxt = '0;
                  if (row_rep_inc >= (stb_pkg::REP_W + 1)'(stb_pkg::MAGNIFY)) begin
                    row_rep_nxt = '0;
                    tex_row_nxt = (tex_row_inc >= lat_th_r) ? 6'd0 : tex_row_inc[5:0];
                  end else begin
                    row_rep_nxt = row_rep_inc[stb_pkg::REP_W-1:0];
                  end
                  cur_row_nxt = row_inc[10:0];
                  if (row_inc >= row_end_r) begin
                    drawing_nxt = 1'b0;
                  end
                end else begin
                  cur_col_nxt = col_inc[10:0];
                end
              end
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
      end
      stb_pkg::BK_WRAP: begin
        if (x_done) begin
          state_nxt         = stb_pkg::BK_RUN;
          tex_col_start_nxt = x_res;
          tex_col_nxt       = x_res;
          tex_row_nxt       = y_res;
          col_rep_nxt       = '0;
          row_rep_nxt       = '0;
          if (empty) begin
            drawing_nxt = 1'b0;
            cur_col_nxt = '0;
            cur_row_nxt = '0;
          end else begin
            drawing_nxt   = 1'b1;
            col_start_nxt = x0[10:0];
            col_end_nxt   = x1c[11:0];
            row_end_nxt   = y1c[11:0];
            cur_col_nxt   = x0[10:0];
            cur_row_nxt   = y0[10:0];
          end
        end
      end
      default: begin
        state_nxt = stb_pkg::BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= stb_pkg::BK_RUN;
      drawing_r       <= 1'b0;
      cur_col_r       <= '0;
      cur_row_r       <= '0;
      tex_col_r       <= '0;
      tex_row_r       <= '0;
      tex_col_start_r <= '0;
      col_rep_r       <= '0;
      row_rep_r       <= '0;
      lat_tw_r        <= 7'd1;
      lat_th_r        <= 7'd1;
      s1_vld_r        <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      drawing_r       <= drawing_nxt;
      cur_col_r       <= cur_col_nxt;
      cur_row_r       <= cur_row_nxt;
      tex_col_r       <= tex_col_nxt;
      tex_row_r       <= tex_row_nxt;
      tex_col_start_r <= tex_col_start_nxt;
      col_rep_r       <= col_rep_nxt;
      row_rep_r       <= row_rep_nxt;
      lat_tw_r        <= lat_tw_nxt;
      lat_th_r        <= lat_th_nxt;
      s1_vld_r        <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_end_r   <= row_end_nxt;
    s1_x_r      <= s1_x_nxt;
    s1_y_r      <= s1_y_nxt;
    s1_last_r   <= s1_last_nxt;
  end

  assign out_valid            = s1_vld_r;
  assign out_pixel.pixel_x    = s1_x_r;
  assign out_pixel.pixel_y    = s1_y_r;
  assign out_pixel.pixel_rgb  = ram_rdata;
  assign out_pixel.last_pixel = s1_last_r;

  `STB_ASSERT_NEXT(a_step_gives_pixel, step_fire, out_valid, "step while drawing lost")
  `STB_ASSERT_IMPL(a_pixel_from_step, out_valid, $past(step_fire), "pixel without a step")
  `STB_ASSERT_IMPL(a_no_pop_in_wrap, state_r == stb_pkg::BK_WRAP, !pop, "pop during wrap")
  `STB_ASSERT_IMPL(a_wrap_in_step, x_done || y_done, x_done && y_done, "wrap units apart")
  `STB_ASSERT_IMPL(a_col_in_bounds, drawing_r, cur_col_ext < col_end_r, "column past end")
  `STB_ASSERT_NEXT(a_last_ends_draw, step_fire && last, !drawing_r, "draw outlived last")

endmodule

`default_nettype wire

// ===== verif/tb_scaled_tiled_texture_blitter_core.sv =====
`timescale 1ns / 100ps

module tb_scaled_tiled_texture_blitter_core;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [stb_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd15;
  localparam int LIMIT = 500000;
  localparam int SETTLE = 120;

  typedef struct {
    bit          drawing;
    logic [11:0] cur_row;
    logic [11:0] cur_col;
    logic [11:0] col_start;
    logic [11:0] col_end;
    logic [11:0] row_end;
    logic [5:0]  tex_row;
    logic [5:0]  tex_col;
    logic [5:0]  tex_col_start;
    logic [3:0]  row_rep;
    logic [3:0]  col_rep;
    logic [6:0]  tw;
    logic [6:0]  th;
  } draw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  stb_pkg::in_item_t in_item = '0;
  logic out_valid;
  stb_pkg::pixel_t out_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [stb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [stb_pkg::CFG_DW-1:0] cfg_wdata = '0;

  stb_pkg::cfg_t regs;
  draw_t plan_draw;
  draw_t live_draw;
  bit texel_loaded [stb_pkg::TEXEL_COUNT];
  logic [23:0] texel_copy [stb_pkg::TEXEL_COUNT];
  stb_pkg::in_item_t items_waiting [$];
  stb_pkg::pixel_t pixels_due [$];
  int unsigned idle_pct = 0;
  int errors = 0;
  int cycles = 0;

  scaled_tiled_texture_blitter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_pixel (out_pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void arm_draw(inout draw_t d);
    int ox, oy, sw, sh, tw, th, x0, y0, x1, y1;
    ox = regs.origin_x;
    oy = regs.origin_y;
    sw = (regs.surf_width > 2048) ? 2048 : int'(regs.surf_width);
    sh = (regs.surf_height > 2048) ? 2048 : int'(regs.surf_height);
    tw = (regs.texture_width == 0) ? 1 :
         (regs.texture_width > 64) ? 64 : int'(regs.texture_width);
    th = (regs.texture_height == 0) ? 1 :
         (regs.texture_height > 64) ? 64 : int'(regs.texture_height);
    x0 = (ox < 0) ? 0 : ox;
    y0 = (oy < 0) ? 0 : oy;
    x1 = ox + int'(regs.rect_width);
    y1 = oy + int'(regs.rect_height);
    if (x1 > sw) x1 = sw;
    if (y1 > sh) y1 = sh;
    d.tw = 7'(tw);
    d.th = 7'(th);
    d.tex_col_start = 6'(((ox % tw) + tw) % tw);
    d.tex_col = d.tex_col_start;
    d.tex_row = 6'(((oy % th) + th) % th);
    d.row_rep = '0;
    d.col_rep = '0;
    if (x0 >= x1 || y0 >= y1) begin
      d.drawing = 1'b0;
      d.cur_row = '0;
      d.cur_col = '0;
    end else begin
      d.col_start = 12'(x0);
      d.col_end = 12'(x1);
      d.row_end = 12'(y1);
      d.cur_col = 12'(x0);
      d.cur_row = 12'(y0);
      d.drawing = 1'b1;
    end
  endfunction

  function automatic logic [11:0] texel_slot(draw_t d);
    return 12'((d.tex_row * d.tw + d.tex_col) % stb_pkg::TEXEL_COUNT);
  endfunction

  // colour is left for the caller to fill from its own store
  function automatic stb_pkg::pixel_t walk_pixel(inout draw_t d);
    stb_pkg::pixel_t p;
    p.pixel_x = d.cur_col[10:0];
    p.pixel_y = d.cur_row[10:0];
    p.pixel_rgb = '0;
    p.last_pixel = (d.cur_col + 1 == d.col_end) && (d.cur_row + 1 == d.row_end);
    d.col_rep = d.col_rep + 1'b1;
    if (d.col_rep >= stb_pkg::MAGNIFY) begin
      d.col_rep = '0;
      d.tex_col = (d.tex_col + 1 >= d.tw) ? 6'd0 : d.tex_col + 1'b1;
    end
    d.cur_col = d.cur_col + 1'b1;
    if (d.cur_col >= d.col_end) begin
      d.cur_col = d.col_start;
      d.tex_col = d.tex_col_start;
      d.col_rep = '0;
      d.row_rep = d.row_rep + 1'b1;
      if (d.row_rep >= stb_pkg::MAGNIFY) begin
        d.row_rep = '0;
        d.tex_row = (d.tex_row + 1 >= d.th) ? 6'd0 : d.tex_row + 1'b1;
      end
      d.cur_row = d.cur_row + 1'b1;
      if (d.cur_row >= d.row_end) d.drawing = 1'b0;
    end
    return p;
  endfunction

  function automatic stb_pkg::in_item_t rand_item(logic [1:0] op);
    stb_pkg::in_item_t it;
    it.op = op;
    it.texel_index = 12'($urandom());
    it.texel_rgb = 24'($urandom());
    return it;
  endfunction

  // a step that would read a never-loaded texel gets a load of that slot first
  function automatic void queue_item(stb_pkg::in_item_t it);
    stb_pkg::in_item_t fill;
    if (it.op == stb_pkg::OP_STEP && plan_draw.drawing &&
        !texel_loaded[texel_slot(plan_draw)]) begin
      fill = rand_item(stb_pkg::OP_LOAD);
      fill.texel_index = texel_slot(plan_draw);
      texel_loaded[fill.texel_index] = 1'b1;
      items_waiting.push_back(fill);
    end
    case (it.op)
      stb_pkg::OP_LOAD: texel_loaded[it.texel_index] = 1'b1;
      stb_pkg::OP_START: arm_draw(plan_draw);
      stb_pkg::OP_STEP: if (plan_draw.drawing) void'(walk_pixel(plan_draw));
      default: ;
    endcase
    items_waiting.push_back(it);
  endfunction

  function automatic int pick_screen();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 4095);
      1, 2: return 2048;
      3, 4: return $urandom_range(1, 24);
      default: return $urandom_range(1, 2048);
    endcase
  endfunction

  function automatic int pick_origin(int screen);
    int lim;
    lim = (screen > 2048) ? 2048 : screen;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1, 2: return lim - int'($urandom_range(0, 10));
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 16383);
      1: return 0;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int pick_texture();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 127);
      1: return 64;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(logic [stb_pkg::CFG_IDX_W-1:0] idx,
                           logic [stb_pkg::CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      stb_pkg::REG_ORIGIN_X: regs.origin_x = val;
      stb_pkg::REG_ORIGIN_Y: regs.origin_y = val;
      stb_pkg::REG_RECT_WIDTH: regs.rect_width = val[13:0];
      stb_pkg::REG_RECT_HEIGHT: regs.rect_height = val[13:0];
      stb_pkg::REG_SURF_WIDTH: regs.surf_width = val[11:0];
      stb_pkg::REG_SURF_HEIGHT: regs.surf_height = val[11:0];
      stb_pkg::REG_TEXTURE_WIDTH: regs.texture_width = val[6:0];
      stb_pkg::REG_TEXTURE_HEIGHT: regs.texture_height = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int ox, int oy, int rw, int rh, int sw, int sh, int tw, int th);
    write_reg(stb_pkg::REG_ORIGIN_X, 16'(ox));
    write_reg(stb_pkg::REG_ORIGIN_Y, 16'(oy));
    write_reg(stb_pkg::REG_RECT_WIDTH, 16'(rw));
    write_reg(stb_pkg::REG_RECT_HEIGHT, 16'(rh));
    write_reg(stb_pkg::REG_SURF_WIDTH, 16'(sw));
    write_reg(stb_pkg::REG_SURF_HEIGHT, 16'(sh));
    write_reg(stb_pkg::REG_TEXTURE_WIDTH, 16'(tw));
    write_reg(stb_pkg::REG_TEXTURE_HEIGHT, 16'(th));
    cfg_valid <= 1'b0;
  endtask

  // start keeps the engine busy without a result, hence the settle time
  task automatic drain();
    while (items_waiting.size() != 0 || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin : feed
    stb_pkg::pixel_t px;
    logic [11:0] slot;
    if (start && !busy) begin
      case (in_item.op)
        stb_pkg::OP_LOAD: texel_copy[in_item.texel_index] = in_item.texel_rgb;
        stb_pkg::OP_START: arm_draw(live_draw);
        stb_pkg::OP_STEP: begin
          if (live_draw.drawing) begin
            slot = texel_slot(live_draw);
            px = walk_pixel(live_draw);
            px.pixel_rgb = texel_copy[slot];
            pixels_due.push_back(px);
          end
        end
        default: ;
      endcase
      void'(items_waiting.pop_front());
    end
    if (!start || !busy) begin
      if (items_waiting.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_item <= items_waiting[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    stb_pkg::pixel_t want;
    if (rst_n && out_valid) begin
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: stray pixel: expected none, actual x=%0d y=%0d rgb=%06h last=%0b",
                   $time, out_pixel.pixel_x, out_pixel.pixel_y, out_pixel.pixel_rgb,
                   out_pixel.last_pixel);
      end else begin
        want = pixels_due.pop_front();
        if (out_pixel.pixel_x !== want.pixel_x || out_pixel.pixel_y !== want.pixel_y ||
            out_pixel.pixel_rgb !== want.pixel_rgb ||
            out_pixel.last_pixel !== want.last_pixel) begin
          errors++;
          if (errors <= 50)
            $display("%0t: expected %0d,%0d %06h %0b actual %0d,%0d %06h %0b",
                     $time, want.pixel_x, want.pixel_y, want.pixel_rgb, want.last_pixel,
                     out_pixel.pixel_x, out_pixel.pixel_y, out_pixel.pixel_rgb,
                     out_pixel.last_pixel);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    stb_pkg::in_item_t it;
    int modes [4];
    int made, left;
    modes = '{0, 77, 0, 36};
    regs.origin_x = '0;
    regs.origin_y = '0;
    regs.rect_width = '0;
    regs.rect_height = '0;
    regs.surf_width = 12'd640;
    regs.surf_height = 12'd480;
    regs.texture_width = 7'd64;
    regs.texture_height = 7'd64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty rectangle, stray steps, unused op, load extremes
    queue_item(rand_item(stb_pkg::OP_STEP));
    queue_item(rand_item(OP_UNUSED));
    queue_item(rand_item(stb_pkg::OP_START));
    queue_item(rand_item(stb_pkg::OP_STEP));
    it = rand_item(stb_pkg::OP_LOAD);
    it.texel_index = '1;
    it.texel_rgb = '1;
    queue_item(it);
    it.texel_index = '0;
    it.texel_rgb = '0;
    queue_item(it);
    drain();

    // register extremes, whole rectangle off screen
    write_reg(REG_SPARE, 16'($urandom()));
    set_config(-32768, 32767, 16383, 16383, 4095, 4095, 127, 127);
    queue_item(rand_item(stb_pkg::OP_START));
    queue_item(rand_item(stb_pkg::OP_STEP));
    drain();

    // clipped at zero and at a tiny screen, texture size zero
    set_config(-2, -1, 4, 3, 2, 1, 0, 0);
    queue_item(rand_item(stb_pkg::OP_START));
    repeat (3) queue_item(rand_item(stb_pkg::OP_STEP));
    drain();

    // bottom right corner, restart mid draw
    set_config(2045, 2046, 16383, 16383, 2048, 2048, 64, 64);
    queue_item(rand_item(stb_pkg::OP_START));
    repeat (3) queue_item(rand_item(stb_pkg::OP_STEP));
    queue_item(rand_item(stb_pkg::OP_START));
    repeat (7) queue_item(rand_item(stb_pkg::OP_STEP));
    drain();

    // zero screen width
    set_config(5, 5, 4, 4, 0, 480, 9, 9);
    queue_item(rand_item(stb_pkg::OP_START));
    queue_item(rand_item(stb_pkg::OP_STEP));
    drain();

    foreach (modes[m]) begin
      idle_pct = modes[m];
      repeat (8) begin
        left = pick_screen();
        made = pick_screen();
        set_config(pick_origin(left), pick_origin(made), pick_span(), pick_span(),
                   left, made, pick_texture(), pick_texture());
        made = 0;
        while (made < 50) begin
          case ($urandom_range(0, 19))
            0, 1: queue_item(rand_item(stb_pkg::OP_LOAD));
            2: queue_item(rand_item(stb_pkg::OP_STEP));
            3: queue_item(rand_item(OP_UNUSED));
            default: begin
              queue_item(rand_item(stb_pkg::OP_START));
              // mostly complete draws, some cut short by the next start
              left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 64;
              while (plan_draw.drawing && left > 0) begin
                queue_item(rand_item(stb_pkg::OP_STEP));
                made++;
                left--;
              end
            end
          endcase
          made++;
        end
        drain();
      end
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== scaled_tiled_texture_blitter_core.f =====
+incdir+rtl
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/stb_front.sv
rtl/stb_wrap.sv
rtl/stb_back.sv
rtl/scaled_tiled_texture_blitter_core.sv
verif/tb_scaled_tiled_texture_blitter_core.sv
